### sv/mcdf_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-channel debounce filter.
// Holds channel counts, limit channel assignments, register indexes and the config struct.
// No dependencies.
package mcdf_pkg;

    // Channel counts; the hardware always carries the full sixteen-bit vectors.
    localparam int MAX_CHANNELS = 16;
    localparam int NUM_CHANNELS = 16;

    // Limit switch channel assignments.
    localparam int GANTRY_FWD_CHANNEL = 0;
    localparam int GANTRY_REV_CHANNEL = 1;
    localparam int LIFT_UP_CHANNEL    = 2;
    localparam int LIFT_DOWN_CHANNEL  = 3;

    // Run counter geometry.
    localparam int RUN_WIDTH = 8;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX   = 8'd255;
    localparam logic [RUN_WIDTH-1:0] RUN_START = 8'd1;

    // Configuration port geometry.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LOW_MASK     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIGGER_COUNTS_LOW  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIGGER_COUNTS_HIGH = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_COUNTS_LOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_COUNTS_HIGH = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALARM_ENABLE_MASK   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIFT_INSTALLED      = 3'd6;

    typedef logic [MAX_CHANNELS-1:0] chan_vec_t;
    typedef logic [MAX_CHANNELS-1:0][RUN_WIDTH-1:0] thr_array_t;

    // Decoded configuration as seen by the filter datapath.
    typedef struct packed {
        chan_vec_t  active_low_mask;
        thr_array_t act_count;
        thr_array_t rel_count;
        chan_vec_t  alarm_enable_mask;
        logic       lift_installed;
    } cfg_t;

    // A limit channel reads as active only when it lies among the live channels.
    function automatic logic limit_active(input chan_vec_t conf, input int ch);
        logic res;
        res = 1'b0;
        if (ch >= 0 && ch < NUM_CHANNELS && ch < MAX_CHANNELS) begin
            res = conf[ch];
        end
        return res;
    endfunction

endpackage

### sv/mcdf_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the multi-channel debounce filter.
// Depends on mcdf_pkg for register indexes and the cfg_t struct.
module mcdf_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mcdf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [mcdf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output mcdf_pkg::cfg_t                        cfg
);
    import mcdf_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_LOW_MASK:
                    cfg_reg.active_low_mask <= cfg_data[MAX_CHANNELS-1:0];
                CFG_TRIGGER_COUNTS_LOW:
                    cfg_reg.act_count[7:0] <= cfg_data;
                CFG_TRIGGER_COUNTS_HIGH:
                    cfg_reg.act_count[15:8] <= cfg_data;
                CFG_RELEASE_COUNTS_LOW:
                    cfg_reg.rel_count[7:0] <= cfg_data;
                CFG_RELEASE_COUNTS_HIGH:
                    cfg_reg.rel_count[15:8] <= cfg_data;
                CFG_ALARM_ENABLE_MASK:
                    cfg_reg.alarm_enable_mask <= cfg_data[MAX_CHANNELS-1:0];
                CFG_LIFT_INSTALLED:
                    cfg_reg.lift_installed <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/mcdf_channel.sv
`timescale 1ns / 1ps
// One debounce channel: run counter, last level and confirmed state.
// Depends on mcdf_pkg for the run counter constants.
module mcdf_channel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               upd,
    input  logic                               ready,
    input  logic                               raw_bit,
    input  logic                               invert,
    input  logic [mcdf_pkg::RUN_WIDTH-1:0]     act_count,
    input  logic [mcdf_pkg::RUN_WIDTH-1:0]     rel_count,
    output logic                               conf_out,
    output logic                               changed
);
    import mcdf_pkg::*;

    logic                 conf_reg;
    logic                 conf_next;
    logic                 prev_reg;
    logic                 prev_next;
    logic [RUN_WIDTH-1:0] run_reg;
    logic [RUN_WIDTH-1:0] run_next;
    logic                 lvl;
    logic [RUN_WIDTH-1:0] thr;
    logic                 flip;

    // Run counter: saturate on a repeated level, restart on a new one.
    always_comb
    begin
        lvl = raw_bit ^ invert;
        if (lvl == prev_reg)
        begin
            prev_next = prev_reg;
            run_next  = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + RUN_START;
        end
        else
        begin
            prev_next = lvl;
            run_next  = RUN_START;
        end
        thr       = lvl ? act_count : rel_count;
        flip      = (run_next >= thr) && (conf_reg != lvl);
        conf_next = flip ? lvl : conf_reg;
    end

    // State update only on a tick with ready inputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg <= 1'b0;
            prev_reg <= 1'b0;
            run_reg  <= '0;
        end
        else if (upd)
        begin
            conf_reg <= conf_next;
            prev_reg <= prev_next;
            run_reg  <= run_next;
        end
    end

    // A skipped tick reports the held state and no change.
    assign conf_out = ready ? conf_next : conf_reg;
    assign changed  = ready & flip;

endmodule

### sv/multi_channel_debounce_filter.sv
`timescale 1ns / 1ps
// Top level of the multi-channel debounce filter.
// Depends on mcdf_pkg, mcdf_cfg_regs and mcdf_channel.
//
// Sixteen-channel counter debounce filter. Every accepted input beat yields exactly one
// result beat: the beat lands in an input register, all channels update in one pass of
// short per-channel logic (an 8-bit increment and compare each), and the result lands in
// an output register, where it is held until taken, longer if the output side stalls. The
// block takes one beat per cycle sustained while the output side does not stall; while a
// finished result waits to be taken, one more beat is accepted into the empty input
// register, after which the input side stalls.
// Configuration writes take effect at the next clock edge and are meant to be made
// while no beat is in flight.
module multi_channel_debounce_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mcdf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [mcdf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [15:0]                           raw_levels,
    input  logic                                  inputs_ready,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           confirmed_states,
    output logic [15:0]                           alarm_triggers,
    output logic [15:0]                           changed_channels,
    output logic                                  gantry_limit_fault,
    output logic                                  lift_limit_fault,
    output logic                                  tick_skipped
);
    import mcdf_pkg::*;

    cfg_t      cfg;
    logic      in_v_reg;
    chan_vec_t raw_reg;
    logic      rdy_reg;
    logic      out_v_reg;
    logic      adv;
    logic      upd;
    chan_vec_t conf_vec;
    chan_vec_t chg_vec;
    chan_vec_t conf_reg;
    chan_vec_t alarm_reg;
    chan_vec_t chg_reg;
    logic      gantry_reg;
    logic      lift_reg;
    logic      skip_reg;

    mcdf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control: the output register takes a beat when empty or being drained.
    assign adv      = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !adv;
    assign upd      = adv && in_v_reg && rdy_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            raw_reg <= raw_levels;
            rdy_reg <= inputs_ready;
        end
    end

    // Per-channel debounce cells; channels past the live count read inactive.
    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_chan
        if (i < NUM_CHANNELS)
        begin : g_live
            mcdf_channel u_chan (
                .clk        (clk),
                .rst_n      (rst_n),
                .upd        (upd),
                .ready      (rdy_reg),
                .raw_bit    (raw_reg[i]),
                .invert     (cfg.active_low_mask[i]),
                .act_count  (cfg.act_count[i]),
                .rel_count  (cfg.rel_count[i]),
                .conf_out   (conf_vec[i]),
                .changed    (chg_vec[i])
            );
        end
        else
        begin : g_idle
            assign conf_vec[i] = 1'b0;
            assign chg_vec[i]  = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_v_reg)
        begin
            conf_reg   <= conf_vec;
            alarm_reg  <= conf_vec & cfg.alarm_enable_mask;
            chg_reg    <= chg_vec;
            gantry_reg <= limit_active(conf_vec, GANTRY_FWD_CHANNEL)
                          & limit_active(conf_vec, GANTRY_REV_CHANNEL);
            lift_reg   <= cfg.lift_installed
                          & limit_active(conf_vec, LIFT_UP_CHANNEL)
                          & limit_active(conf_vec, LIFT_DOWN_CHANNEL);
            skip_reg   <= !rdy_reg;
        end
    end

    assign out_valid          = out_v_reg;
    assign confirmed_states   = conf_reg;
    assign alarm_triggers     = alarm_reg;
    assign changed_channels   = chg_reg;
    assign gantry_limit_fault = gantry_reg;
    assign lift_limit_fault   = lift_reg;
    assign tick_skipped       = skip_reg;

endmodule

### sv/mcdf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the multi-channel debounce filter, with its bind statement.
// Depends on mcdf_pkg for the limit channel assignments.
module mcdf_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] confirmed_states,
    input logic [15:0] alarm_triggers,
    input logic [15:0] changed_channels,
    input logic        gantry_limit_fault,
    input logic        lift_limit_fault,
    input logic        tick_skipped
);
    import mcdf_pkg::*;

    // A stalled result beat stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A skipped tick never reports a change.
    a_skip_nochg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tick_skipped |-> changed_channels == 16'd0)
        else $error("changed channels on a skipped tick");

    // Alarms are a subset of the confirmed states.
    a_alarm_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alarm_triggers & ~confirmed_states) == 16'd0)
        else $error("alarm on an inactive channel");

    // Fault flags agree with the confirmed limit channels.
    a_faults: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gantry_limit_fault == (confirmed_states[GANTRY_FWD_CHANNEL]
                                             & confirmed_states[GANTRY_REV_CHANNEL]))
                   && (!lift_limit_fault || (confirmed_states[LIFT_UP_CHANNEL]
                                             & confirmed_states[LIFT_DOWN_CHANNEL])))
        else $error("limit fault does not match confirmed states");

endmodule

bind multi_channel_debounce_filter mcdf_port_checks u_port_checks (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .confirmed_states   (confirmed_states),
    .alarm_triggers     (alarm_triggers),
    .changed_channels   (changed_channels),
    .gantry_limit_fault (gantry_limit_fault),
    .lift_limit_fault   (lift_limit_fault),
    .tick_skipped       (tick_skipped)
);

### test/mcdf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-channel debounce filter testbench: it mirrors the register
// writes, predicts one result beat per accepted input beat and compares them in order.
// Depends on mcdf_pkg.
module mcdf_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mcdf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mcdf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [15:0]                          raw_levels,
    input  logic                                 inputs_ready,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [15:0]                          confirmed_states,
    input  logic [15:0]                          alarm_triggers,
    input  logic [15:0]                          changed_channels,
    input  logic                                 gantry_limit_fault,
    input  logic                                 lift_limit_fault,
    input  logic                                 tick_skipped,
    output int unsigned                          mismatch_count,
    output int unsigned                          beats_in_flight
);
    import mcdf_pkg::*;

    localparam int LIVE_CHANNELS = (NUM_CHANNELS > 16) ? 16 : NUM_CHANNELS;
    localparam logic [7:0] RUN_CEILING = 8'd255;
    localparam int REPORT_LIMIT = 10;

    // One predicted result beat.
    typedef struct packed {
        logic [15:0] states;
        logic [15:0] alarms;
        logic [15:0] changed;
        logic        gantry_fault;
        logic        lift_fault;
        logic        skipped;
    } tick_result_t;

    tick_result_t expected_q[$];

    // Mirrored configuration.
    logic [15:0] pol_mask;
    logic [15:0] alarm_mask;
    logic        lift_fitted;
    logic [7:0]  trig_cnt [16];
    logic [7:0]  rel_cnt [16];

    // Mirrored filter state.
    logic [15:0] conf_q;
    logic [15:0] last_level;
    logic [7:0]  run_len [16];

    int unsigned err_total;

    // A limit channel counts only when it lies among the live channels.
    function automatic logic channel_asserted(int ch);
        return (ch >= 0 && ch < LIVE_CHANNELS) ? conf_q[ch] : 1'b0;
    endfunction

    // Advance the debounce state by one tick and build the result it reports.
    function automatic tick_result_t debounce_tick(logic [15:0] raw, logic ready);
        tick_result_t res;
        logic [15:0]  level;
        logic [7:0]   needed;
        res = '0;
        if (ready) begin
            level = raw ^ pol_mask;
            for (int ch = 0; ch < LIVE_CHANNELS; ch++) begin
                // Same level extends the run; a new level restarts it at one.
                if (level[ch] == last_level[ch]) begin
                    if (run_len[ch] < RUN_CEILING)
                        run_len[ch] = run_len[ch] + 8'd1;
                end
                else begin
                    last_level[ch] = level[ch];
                    run_len[ch] = 8'd1;
                end
                needed = level[ch] ? trig_cnt[ch] : rel_cnt[ch];
                if (run_len[ch] >= needed && conf_q[ch] != level[ch]) begin
                    conf_q[ch] = level[ch];
                    res.changed[ch] = 1'b1;
                end
            end
        end
        res.states       = conf_q;
        res.alarms       = conf_q & alarm_mask;
        res.gantry_fault = channel_asserted(GANTRY_FWD_CHANNEL)
                           && channel_asserted(GANTRY_REV_CHANNEL);
        res.lift_fault   = lift_fitted && channel_asserted(LIFT_UP_CHANNEL)
                           && channel_asserted(LIFT_DOWN_CHANNEL);
        res.skipped      = !ready;
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            err_total++;
            if (err_total <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Watch the register port and both channels.
    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        if (!rst_n) begin
            pol_mask    = '0;
            alarm_mask  = '0;
            lift_fitted = 1'b0;
            conf_q      = '0;
            last_level  = '0;
            for (int ch = 0; ch < 16; ch++) begin
                trig_cnt[ch] = '0;
                rel_cnt[ch]  = '0;
                run_len[ch]  = '0;
            end
            expected_q.delete();
            err_total = 0;
        end
        else begin
            // Register writes; an unknown index is ignored.
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACTIVE_LOW_MASK: pol_mask = cfg_data[15:0];
                    CFG_TRIGGER_COUNTS_LOW:
                        for (int k = 0; k < 8; k++) trig_cnt[k] = cfg_data[8*k +: 8];
                    CFG_TRIGGER_COUNTS_HIGH:
                        for (int k = 0; k < 8; k++) trig_cnt[k+8] = cfg_data[8*k +: 8];
                    CFG_RELEASE_COUNTS_LOW:
                        for (int k = 0; k < 8; k++) rel_cnt[k] = cfg_data[8*k +: 8];
                    CFG_RELEASE_COUNTS_HIGH:
                        for (int k = 0; k < 8; k++) rel_cnt[k+8] = cfg_data[8*k +: 8];
                    CFG_ALARM_ENABLE_MASK: alarm_mask = cfg_data[15:0];
                    CFG_LIFT_INSTALLED: lift_fitted = cfg_data[0];
                    default: ;
                endcase
            end

            // Result beats are compared before this edge's input beat is predicted.
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    err_total++;
                    if (err_total <= REPORT_LIMIT)
                        $display("unexpected result beat: states %h changed %h",
                                 confirmed_states, changed_channels);
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("confirmed_states", want.states, confirmed_states);
                    check_field("alarm_triggers", want.alarms, alarm_triggers);
                    check_field("changed_channels", want.changed, changed_channels);
                    check_field("gantry_limit_fault", 16'(want.gantry_fault),
                                16'(gantry_limit_fault));
                    check_field("lift_limit_fault", 16'(want.lift_fault),
                                16'(lift_limit_fault));
                    check_field("tick_skipped", 16'(want.skipped), 16'(tick_skipped));
                end
            end

            if (in_valid && !in_stall)
                expected_q.push_back(debounce_tick(raw_levels, inputs_ready));
        end
        mismatch_count  <= err_total;
        beats_in_flight <= expected_q.size();
    end

endmodule

### test/multi_channel_debounce_filter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the multi-channel debounce filter: drives register phases and input
// beats with random idling and output stalls, and reports the verdict.
// Depends on mcdf_pkg, mcdf_checker and multi_channel_debounce_filter.
module multi_channel_debounce_filter_tb;
    import mcdf_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_INDEX = 3'd7;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BEATS [NUM_PHASES] = '{150, 150, 320, 150, 150, 100};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic [15:0]                raw_levels = '0;
    logic                       inputs_ready = 1'b0;
    logic                       out_stall = 1'b0;
    logic                       in_stall;
    logic                       out_valid;
    logic [15:0]                confirmed_states;
    logic [15:0]                alarm_triggers;
    logic [15:0]                changed_channels;
    logic                       gantry_limit_fault;
    logic                       lift_limit_fault;
    logic                       tick_skipped;
    int unsigned                mismatch_count;
    int unsigned                beats_in_flight;

    // Stimulus shaping: no idling while quiet, per-channel toggle odds and noise rate.
    bit          quiet = 1'b0;
    int          cycle_count = 0;
    logic [15:0] held_levels = '0;
    int          flip_odds [16];
    int          noise_pct = 0;

    multi_channel_debounce_filter u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .raw_levels         (raw_levels),
        .inputs_ready       (inputs_ready),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .confirmed_states   (confirmed_states),
        .alarm_triggers     (alarm_triggers),
        .changed_channels   (changed_channels),
        .gantry_limit_fault (gantry_limit_fault),
        .lift_limit_fault   (lift_limit_fault),
        .tick_skipped       (tick_skipped)
    );

    mcdf_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .raw_levels         (raw_levels),
        .inputs_ready       (inputs_ready),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .confirmed_states   (confirmed_states),
        .alarm_triggers     (alarm_triggers),
        .changed_channels   (changed_channels),
        .gantry_limit_fault (gantry_limit_fault),
        .lift_limit_fault   (lift_limit_fault),
        .tick_skipped       (tick_skipped),
        .mismatch_count     (mismatch_count),
        .beats_in_flight    (beats_in_flight)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls at random, with odds of 8 in a hundred, outside the quiet stretch.
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_tick(input logic [15:0] raw, input logic ready);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        raw_levels   <= raw;
        inputs_ready <= ready;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every result beat has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_in_flight != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write every register once, with junk above the narrow ones, plus the spare index.
    task automatic program_regs(input logic [15:0] pol, input logic [63:0] trig_lo,
                                input logic [63:0] trig_hi, input logic [63:0] rel_lo,
                                input logic [63:0] rel_hi, input logic [15:0] alarm,
                                input logic lift);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_LOW_MASK;
        cfg_data  <= {junk[63:16], pol};
        @(negedge clk);
        cfg_index <= CFG_TRIGGER_COUNTS_LOW;
        cfg_data  <= trig_lo;
        @(negedge clk);
        cfg_index <= CFG_TRIGGER_COUNTS_HIGH;
        cfg_data  <= trig_hi;
        @(negedge clk);
        cfg_index <= CFG_RELEASE_COUNTS_LOW;
        cfg_data  <= rel_lo;
        @(negedge clk);
        cfg_index <= CFG_RELEASE_COUNTS_HIGH;
        cfg_data  <= rel_hi;
        @(negedge clk);
        cfg_index <= CFG_ALARM_ENABLE_MASK;
        cfg_data  <= {junk[47:0], alarm};
        @(negedge clk);
        cfg_index <= CFG_LIFT_INSTALLED;
        cfg_data  <= {junk[63:1], lift};
        @(negedge clk);
        cfg_index <= CFG_SPARE_INDEX;
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Run length for one channel: mostly short, sometimes zero, now and then the maximum.
    function automatic logic [7:0] random_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return 8'd0;
        else if (roll < 55)
            return 8'($urandom_range(1, 4));
        else if (roll < 80)
            return 8'($urandom_range(5, 16));
        else if (roll < 90)
            return 8'($urandom_range(17, 254));
        return 8'd255;
    endfunction

    function automatic logic [63:0] random_counts();
        logic [63:0] word;
        for (int k = 0; k < 8; k++) word[8*k +: 8] = random_count();
        return word;
    endfunction

    function automatic int random_odds();
        case ($urandom_range(0, 3))
            0: return 1;
            1: return 4;
            2: return 16;
            default: return 1000;
        endcase
    endfunction

    // Pick registers and stimulus shape for one random phase.
    task automatic start_phase(input int phase);
        for (int ch = 0; ch < 16; ch++) flip_odds[ch] = random_odds();
        quiet = 1'b0;
        case (phase)
            0: begin
                // Every threshold zero, all channels inverted and alarmed.
                program_regs(16'hFFFF, '0, '0, '0, '0, 16'hFFFF, 1'b1);
                for (int ch = 0; ch < 16; ch++) flip_odds[ch] = 1;
                noise_pct = 10;
            end
            1: begin
                // Every threshold at the maximum; only saturated runs can confirm.
                program_regs(16'h0000, '1, '1, '1, '1, 16'h0000, 1'b0);
                noise_pct = 0;
            end
            2: begin
                // Long clean phase without idling so that runs reach saturation.
                program_regs(16'($urandom), random_counts(), random_counts(),
                             random_counts(), random_counts(), 16'($urandom), 1'b1);
                noise_pct = 0;
                quiet = 1'b1;
            end
            default: begin
                program_regs(16'($urandom), random_counts(), random_counts(),
                             random_counts(), random_counts(), 16'($urandom),
                             1'($urandom));
                noise_pct = $urandom_range(0, 15);
            end
        endcase
    endtask

    // Draw one tick: mostly slowly toggling levels, some skipped ticks and some noise.
    task automatic draw_tick(output logic [15:0] raw, output logic ready);
        int roll;
        roll = $urandom_range(0, 99);
        ready = (roll >= 10);
        if (roll < 10 + noise_pct) begin
            raw = 16'($urandom);
        end
        else begin
            for (int ch = 0; ch < 16; ch++)
                if ($urandom_range(0, flip_odds[ch]) == 0)
                    held_levels[ch] = !held_levels[ch];
            raw = held_levels;
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [15:0] raw;
        logic        ready;
        for (int ch = 0; ch < 16; ch++) flip_odds[ch] = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset thresholds are zero: levels are confirmed on the same tick.
        send_tick(16'h0000, 1'b1);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'h0000, 1'b0);
        send_tick(16'h0000, 1'b1);

        // Short thresholds with half the channels inverted, a skip in the middle of a run.
        settle();
        program_regs(16'h00FF, {8{8'd2}}, {8{8'd2}}, {8{8'd3}}, {8{8'd3}},
                     16'hAAAA, 1'b1);
        repeat (3) send_tick(16'hFFFF, 1'b1);
        send_tick(16'hFFFF, 1'b0);
        repeat (4) send_tick(16'h0000, 1'b1);
        send_tick(16'h5555, 1'b1);
        send_tick(16'hAAAA, 1'b1);
        send_tick(16'h5555, 1'b1);
        send_tick(16'hAAAA, 1'b1);

        // Maximum thresholds: nothing may change on short runs.
        settle();
        program_regs(16'h0000, '1, '1, '1, '1, 16'hFFFF, 1'b0);
        repeat (2) send_tick(16'h0000, 1'b1);
        repeat (2) send_tick(16'hFFFF, 1'b1);

        // Random phases.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            start_phase(phase);
            for (int n = 0; n < PHASE_BEATS[phase]; n++) begin
                draw_tick(raw, ready);
                send_tick(raw, ready);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
